### hw/rtl/ps2mct_pkg.sv
// Package: shared types and constants of the PS/2 mouse cursor tracker.
`timescale 1ns / 1ps
package ps2mct_pkg;

    localparam int POS_BITS_DEF   = 12;
    localparam int SIZE_BITS      = 13;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CURSOR_W       = 8;
    localparam int CURSOR_H       = 16;
    localparam int START_POS      = 50;
    localparam logic [SIZE_BITS-1:0] WIDTH_RST  = 13'd640;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RST = 13'd480;

    // Status byte bit positions
    localparam int SYNC_BIT = 3;
    localparam int X_SIGN   = 4;
    localparam int Y_SIGN   = 5;
    localparam int X_OVF    = 6;
    localparam int Y_OVF    = 7;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_XDELTA = 2'd1,
        PH_YDELTA = 2'd2
    } phase_t;

    // Framer view of the packet being assembled
    typedef struct packed {
        logic       last;      // next accepted byte completes a packet
        logic [7:0] status;
        logic [7:0] x_delta;
    } frame_t;

endpackage

### hw/rtl/ps2mct_if.sv
// Interfaces: mouse byte, cursor position and configuration write channels.
`timescale 1ns / 1ps
interface ps2mct_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ps2mct_pos_if #(parameter int POS_BITS = 12);
    logic                valid;
    logic                ready;
    logic [POS_BITS-1:0] cursor_x;
    logic [POS_BITS-1:0] cursor_y;
    modport source (output valid, output cursor_x, output cursor_y, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, output ready);
endinterface

interface ps2mct_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/ps2mct_framer.sv
// Packet framer: tracks byte phase and holds the status and X delta bytes.
`timescale 1ns / 1ps
module ps2mct_framer
    import ps2mct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    output frame_t     frame
);

    phase_t     phase_reg, phase_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] xdelta_reg, xdelta_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_STATUS;
            status_reg <= '0;
            xdelta_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            xdelta_reg <= xdelta_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        status_next = status_reg;
        xdelta_next = xdelta_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_XDELTA:
                begin
                    xdelta_next = data_byte;
                    phase_next  = PH_YDELTA;
                end
                PH_YDELTA:
                begin
                    phase_next = PH_STATUS;
                end
                default:
                begin
                    // drop bytes without the sync bit
                    phase_next = PH_STATUS;
                    if (data_byte[SYNC_BIT])
                    begin
                        status_next = data_byte;
                        phase_next  = PH_XDELTA;
                    end
                end
            endcase
        end
    end

    assign frame.last    = (phase_reg == PH_YDELTA);
    assign frame.status  = status_reg;
    assign frame.x_delta = xdelta_reg;

endmodule

### hw/rtl/ps2mct_update.sv
// Cursor update: applies packet deltas, clamps, holds position and result register.
`timescale 1ns / 1ps
module ps2mct_update
    import ps2mct_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  frame_t               frame,
    input  logic [7:0]           y_byte,
    input  logic [SIZE_BITS-1:0] screen_width,
    input  logic [SIZE_BITS-1:0] screen_height,
    output logic                 busy,
    ps2mct_pos_if.source         cursor
);

    localparam int SW = ((POS_BITS > SIZE_BITS) ? POS_BITS : SIZE_BITS) + 2;
    localparam logic signed [SW-1:0] POS_TOP = SW'((64'd1 << POS_BITS) - 64'd1);

    logic [POS_BITS-1:0] pos_x_reg, pos_x_next;
    logic [POS_BITS-1:0] pos_y_reg, pos_y_next;
    logic [POS_BITS-1:0] out_x_reg, out_y_reg;
    logic                out_valid_reg, out_valid_next;

    logic [9:0]          dx_mag, dy_mag;
    logic signed [SW-1:0] nx, ny;

    // Magnitude of a delta byte plus the overflow extension
    function automatic logic [9:0] delta_mag(input logic [7:0] b, input logic neg,
                                             input logic ovf);
        logic [7:0] m;
        begin
            m = neg ? (8'd0 - b) : b;
            delta_mag = {2'b00, m} + (ovf ? 10'd255 : 10'd0);
        end
    endfunction

    function automatic logic [POS_BITS-1:0] clamp(input logic signed [SW-1:0] v,
                                                  input logic [SIZE_BITS-1:0] size,
                                                  input logic [SIZE_BITS-1:0] margin);
        logic signed [SW-1:0] lim;
        logic signed [SW-1:0] r;
        begin
            lim = (size >= margin) ? $signed(SW'(size - margin)) : '0;
            if (lim > POS_TOP)
                lim = POS_TOP;
            r = v;
            if (r < 0)
                r = '0;
            if (r > lim)
                r = lim;
            clamp = r[POS_BITS-1:0];
        end
    endfunction

    always_comb
    begin
        dx_mag = delta_mag(frame.x_delta, frame.status[X_SIGN], frame.status[X_OVF]);
        dy_mag = delta_mag(y_byte, frame.status[Y_SIGN], frame.status[Y_OVF]);
        nx = $signed(SW'(pos_x_reg));
        ny = $signed(SW'(pos_y_reg));
        if (frame.status[X_SIGN])
            nx = nx - $signed(SW'(dx_mag));
        else
            nx = nx + $signed(SW'(dx_mag));
        // packet Y points up, screen Y points down
        if (frame.status[Y_SIGN])
            ny = ny + $signed(SW'(dy_mag));
        else
            ny = ny - $signed(SW'(dy_mag));

        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        if (fire)
        begin
            pos_x_next = clamp(nx, screen_width, SIZE_BITS'(CURSOR_W));
            pos_y_next = clamp(ny, screen_height, SIZE_BITS'(CURSOR_H));
        end

        out_valid_next = out_valid_reg;
        if (cursor.ready)
            out_valid_next = 1'b0;
        if (fire)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= POS_BITS'(START_POS);
            pos_y_reg     <= POS_BITS'(START_POS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_x_reg <= pos_x_next;
            out_y_reg <= pos_y_next;
        end
    end

    assign busy            = out_valid_reg && !cursor.ready;
    assign cursor.valid    = out_valid_reg;
    assign cursor.cursor_x = out_x_reg;
    assign cursor.cursor_y = out_y_reg;

endmodule

### hw/rtl/ps2_mouse_cursor_tracker.sv
// Top level of the PS/2 mouse cursor tracker.
//
//  Channel  Dir  Payload                  Beat carries
//  mouse    in   data_byte[7:0]           one raw mouse byte
//  cursor   out  cursor_x, cursor_y       clamped cursor after a packet
//  cfg      in   index[1:0], data[12:0]   screen width / height write
//
// One byte per cycle if not stalled: the cursor add and clamp sit between
// the framer and result registers, so every byte completes in its beat.
// The third byte of a packet loads the result register at its own accepting
// edge; the cursor beat is offered from the next cycle on.
// Reset: screen 640x480, cursor at (50,50), framer waiting for a status byte.
// A stalled result blocks only a packet's third byte; status and X beats keep
// flowing into the framer while the result waits.
`timescale 1ns / 1ps
module ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    ps2mct_byte_if.sink  mouse,
    ps2mct_pos_if.source cursor,
    ps2mct_cfg_if.sink   cfg
);

    logic [SIZE_BITS-1:0] width_reg, width_next;
    logic [SIZE_BITS-1:0] height_reg, height_next;
    frame_t               frame;
    logic                 busy;
    logic                 accept;
    logic                 fire;

    // Configuration: always ready, ignore indexes beyond the register list
    assign cfg.ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SCREEN_WIDTH:  width_next  = cfg.data;
                REG_SCREEN_HEIGHT: height_next = cfg.data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Hold only the packet-closing byte while the result register is stalled
    assign mouse.ready = !(frame.last && busy);
    assign accept      = mouse.valid && mouse.ready;
    assign fire        = accept && frame.last;

    ps2mct_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (mouse.data_byte),
        .frame     (frame)
    );

    ps2mct_update #(
        .POS_BITS (POS_BITS)
    ) u_update (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .frame         (frame),
        .y_byte        (mouse.data_byte),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .busy          (busy),
        .cursor        (cursor)
    );

endmodule
